// File: design/decimal_radix_sorter_defines.svh
// Assertion helpers shared by the sorter RTL
`ifndef DECIMAL_RADIX_SORTER_DEFINES_SVH
`define DECIMAL_RADIX_SORTER_DEFINES_SVH

// same-cycle implication
`define DRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/drs_pkg.sv
package drs_pkg;

   localparam int KEY_W    = 17;
   localparam int DIG_W    = 4;
   localparam int RADIX    = 10;
   localparam logic [KEY_W-1:0] KEY_MAX = 17'd99999;

   // q / 10 == (q * RECIP) >> RECIP_SHIFT, exact for every 17-bit q
   localparam int RECIP_W     = 18;
   localparam logic [RECIP_W-1:0] RECIP = 18'd209716;
   localparam int RECIP_SHIFT = 21;
   localparam int PROD_W      = KEY_W + RECIP_W;
   localparam int QUO_W       = PROD_W - RECIP_SHIFT;

   typedef struct packed {
      logic [KEY_W-1:0] key_in;
      logic             last_key;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] key_out;
      logic             last_out;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      logic load;       // key transfer on the request side
      logic clr_set;    // set delivered, start a new one
      logic idx_clr;
      logic cnt_clear;
      logic issue;      // read next stored entry into the digit pipe
      logic scatter;    // pipe also writes to the other buffer at the bucket position
      logic pfx_init;
      logic pfx_step;
      logic swap;       // pass done, buffers change roles
      logic out_issue;
      logic out_latch;
   } cmd_type;

   typedef struct packed {
      logic idx_done;
      logic pipe_empty;
      logic pfx_done;
      logic pass_done;
      logic rsp_taken;
      logic out_last;
   } status_type;

endpackage

// File: design/drs_ram.sv
module drs_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: design/drs_datapath.sv
module drs_datapath #(
   parameter int MAX_KEYS     = 64,
   parameter int DIGIT_PASSES = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  drs_pkg::cmd_type     cmd,
   input  drs_pkg::req_type     req_data,
   output drs_pkg::status_type  status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output drs_pkg::rsp_type     rsp_data
);
   import drs_pkg::*;

   localparam int AW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam int PW = $clog2(DIGIT_PASSES + 1);
   localparam int EW = 2 * KEY_W;   // entry: {key, remaining quotient}

   logic [CW-1:0]     n_ff, idx_ff, sum_ff;
   logic              drop_ff, src_ff, v1_ff, v2_ff, rsp_valid_ff;
   logic [PW-1:0]     pass_ff;
   logic [DIG_W-1:0]  pfx_ff;
   logic [CW-1:0]     cnt_ff [RADIX];
   logic [PROD_W-1:0] prod_ff;
   logic [KEY_W-1:0]  key2_ff, q2_ff;
   rsp_type           rsp_ff;

   logic [KEY_W-1:0]  key_sat, q1, quo10, diff;
   logic [QUO_W-1:0]  quo;
   logic [DIG_W-1:0]  digit;
   logic [EW-1:0]     rd0, rd1, rd_sel, wdata;
   logic [AW-1:0]     waddr;
   logic              load_wr, sct_wr, we0, we1;

   assign key_sat = (req_data.key_in > KEY_MAX) ? KEY_MAX : req_data.key_in;
   assign load_wr = cmd.load && (n_ff < CW'(MAX_KEYS));
   assign rd_sel  = src_ff ? rd1 : rd0;
   assign q1      = rd_sel[KEY_W-1:0];

   assign quo   = prod_ff[PROD_W-1:RECIP_SHIFT];
   assign quo10 = KEY_W'({quo, 3'b000}) + KEY_W'({quo, 1'b0});
   assign diff  = q2_ff - quo10;
   assign digit = diff[DIG_W-1:0];

   assign sct_wr = v2_ff && cmd.scatter;
   // loads fill the current buffer, a scatter fills the other one
   assign waddr  = load_wr ? n_ff[AW-1:0] : cnt_ff[digit][AW-1:0];
   assign wdata  = load_wr ? {key_sat, key_sat} : {key2_ff, KEY_W'(quo)};
   assign we0    = (load_wr && !src_ff) || (sct_wr && src_ff);
   assign we1    = (load_wr && src_ff) || (sct_wr && !src_ff);

   drs_ram #(.WIDTH(EW), .DEPTH(MAX_KEYS)) u_ram0 (
      .clock(clock), .wr_en(we0), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(idx_ff[AW-1:0]), .rd_data(rd0)
   );

   drs_ram #(.WIDTH(EW), .DEPTH(MAX_KEYS)) u_ram1 (
      .clock(clock), .wr_en(we1), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(idx_ff[AW-1:0]), .rd_data(rd1)
   );

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(q1) * PROD_W'(RECIP);
      key2_ff <= rd_sel[EW-1:KEY_W];
      q2_ff   <= q1;
      if (cmd.out_latch) begin
         rsp_ff.key_out  <= rd_sel[EW-1:KEY_W];
         rsp_ff.last_out <= (idx_ff == n_ff);
         rsp_ff.overflow <= drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         drop_ff      <= 1'b0;
         idx_ff       <= '0;
         src_ff       <= 1'b0;
         pass_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         pfx_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < RADIX; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         if (cmd.load) begin
            if (load_wr) begin
               n_ff <= n_ff + CW'(1);
            end else begin
               drop_ff <= 1'b1;
            end
         end
         if (cmd.clr_set) begin
            n_ff    <= '0;
            drop_ff <= 1'b0;
         end
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.issue || cmd.out_issue) begin
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.cnt_clear) begin
            for (int i = 0; i < RADIX; i++) begin
               cnt_ff[i] <= '0;
            end
         end else if (cmd.pfx_step) begin
            // counts turn into bucket start positions
            cnt_ff[pfx_ff] <= sum_ff;
         end else if (v2_ff) begin
            cnt_ff[digit] <= cnt_ff[digit] + CW'(1);
         end
         if (cmd.pfx_init) begin
            pfx_ff <= '0;
            sum_ff <= '0;
         end else if (cmd.pfx_step) begin
            pfx_ff <= pfx_ff + DIG_W'(1);
            sum_ff <= sum_ff + cnt_ff[pfx_ff];
         end
         if (cmd.swap) begin
            src_ff  <= !src_ff;
            pass_ff <= status.pass_done ? '0 : pass_ff + PW'(1);
         end
         if (cmd.out_latch) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.idx_done   = (idx_ff == n_ff);
   assign status.pipe_empty = !v1_ff && !v2_ff;
   assign status.pfx_done   = (pfx_ff == DIG_W'(RADIX - 1));
   assign status.pass_done  = (pass_ff == PW'(DIGIT_PASSES - 1));
   assign status.rsp_taken  = rsp_valid_ff && !rsp_stall;
   assign status.out_last   = rsp_ff.last_out;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// File: design/drs_ctrl.sv
module drs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   input  drs_pkg::status_type status,
   output drs_pkg::cmd_type    cmd,
   output logic                req_stall
);
   import drs_pkg::*;

   localparam logic [2:0] ST_LOAD     = 3'd0;
   localparam logic [2:0] ST_COUNT    = 3'd1;
   localparam logic [2:0] ST_PREFIX   = 3'd2;
   localparam logic [2:0] ST_SCATTER  = 3'd3;
   localparam logic [2:0] ST_OUT_RD   = 3'd4;
   localparam logic [2:0] ST_OUT_LAT  = 3'd5;
   localparam logic [2:0] ST_OUT_WAIT = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.load = req_valid;
            if (req_valid && req_last) begin
               cmd.idx_clr   = 1'b1;
               cmd.cnt_clear = 1'b1;
               state_in      = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cmd.issue = !status.idx_done;
            if (status.idx_done && status.pipe_empty) begin
               cmd.pfx_init = 1'b1;
               state_in     = ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            cmd.pfx_step = 1'b1;
            if (status.pfx_done) begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_SCATTER;
            end
         end
         ST_SCATTER: begin
            cmd.scatter = 1'b1;
            cmd.issue   = !status.idx_done;
            if (status.idx_done && status.pipe_empty) begin
               cmd.swap    = 1'b1;
               cmd.idx_clr = 1'b1;
               if (status.pass_done) begin
                  state_in = ST_OUT_RD;
               end else begin
                  cmd.cnt_clear = 1'b1;
                  state_in      = ST_COUNT;
               end
            end
         end
         ST_OUT_RD: begin
            cmd.out_issue = 1'b1;
            state_in      = ST_OUT_LAT;
         end
         ST_OUT_LAT: begin
            cmd.out_latch = 1'b1;
            state_in      = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (status.rsp_taken) begin
               if (status.out_last) begin
                  cmd.clr_set = 1'b1;
                  state_in    = ST_LOAD;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_LOAD);
endmodule

// File: design/decimal_radix_sorter.sv
// Keys load at one per cycle while req_stall is low; a set closes on the key marked last.
// Sorting then runs DIGIT_PASSES passes over the N stored keys: each pass
// counts digits, builds the ten bucket starts and scatters, one key per cycle.
// Each result is read, latched, then held until taken; input stalls until the set is out.
// Synchronous reset returns control to load with empty counts; key buffers are not cleared.
module decimal_radix_sorter #(
   parameter int MAX_KEYS     = 64,
   parameter int DIGIT_PASSES = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  drs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output drs_pkg::rsp_type rsp_data
);
   import drs_pkg::*;
`include "decimal_radix_sorter_defines.svh"

   cmd_type    cmd;
   status_type status;

   drs_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_last(req_data.last_key),
      .status(status), .cmd(cmd), .req_stall(req_stall)
   );

   drs_datapath #(.MAX_KEYS(MAX_KEYS), .DIGIT_PASSES(DIGIT_PASSES)) u_dp (
      .clock(clock), .reset(reset),
      .cmd(cmd), .req_data(req_data), .status(status),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   `DRS_ASSERT_NOW(a_no_load_while_out, clock, reset, rsp_valid, req_stall, "input open while emitting")
   `DRS_ASSERT_NEXT(a_last_reopens, clock, reset, rsp_valid && !rsp_stall && rsp_data.last_out, !req_stall, "set end did not reopen input")
   `DRS_ASSERT_NEXT(a_mid_stays_closed, clock, reset, rsp_valid && !rsp_stall && !rsp_data.last_out, req_stall, "input opened mid set")
   `DRS_ASSERT_NOW(a_one_cmd_src, clock, reset, cmd.issue, !cmd.out_issue && !cmd.load, "conflicting index commands")
endmodule
